/* rtl/ccsc_pkg.sv */
// shared types, constants and helpers for the crc codeword stream checker
// no dependencies; the top, front and back refer to it by scoped names
`timescale 1ns / 1ps

package ccsc_pkg;

   localparam int BUFFER_BITS_DEF = 24;
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_GEN_POLY   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GEN_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DW_EIGHT   = 2'd2;

   localparam logic [8:0] GEN_POLY_RST   = 9'd263;
   localparam logic [3:0] GEN_LENGTH_RST = 4'd9;
   localparam logic       DW_EIGHT_RST   = 1'b1;

   localparam logic MODE_HEADER = 1'b0;
   localparam logic MODE_DATA   = 1'b1;

   typedef enum logic {
      CMD_CLEAR = 1'b0,
      CMD_CHECK = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        codeword_error;
      logic        out_byte_valid;
      logic [7:0]  out_byte;
      logic [31:0] codeword_total;
      logic [31:0] error_total;
      logic        last;
   } rsp_type;

   // work handed from the front to the back
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   dataword;
      logic [7:0]   check_bits;
      logic         last;
   } cmd_type;

   // live configuration, generator length already clamped to 2..9
   typedef struct packed {
      logic [8:0] gen_poly;
      logic [3:0] gen_length;
      logic       dw_eight;
   } cfg_type;

   function automatic logic [3:0] clamp_gen_length(input logic [3:0] raw);
      logic [3:0] g;
      g = raw;
      if (raw < 4'd2) g = 4'd2;
      if (raw > 4'd9) g = 4'd9;
      return g;
   endfunction

endpackage

/* rtl/crc_codeword_stream_checker_top.sv */
// a request's result passes through the command queue and then the result queue;
//   the second codeword of a request follows the first
// the front cuts one codeword per cycle into the command queue while it has room,
//   and takes no new request while the second codeword of a byte is pending
// reset: synchronous, active high; clears the bit buffer, packer, counters and
//   both queues, and loads the generator registers with 263, 9 and 8-bit datawords
// top level; depends on ccsc_pkg, ccsc_fifo, ccsc_front and ccsc_back
`timescale 1ns / 1ps

module crc_codeword_stream_checker_top #(
   parameter int BUFFER_BITS = ccsc_pkg::BUFFER_BITS_DEF,
   parameter int COUNT_WIDTH = ccsc_pkg::COUNT_WIDTH_DEF,
   parameter int QUEUE_DEPTH = ccsc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  ccsc_pkg::req_type                   req_data,
   output logic                                req_full,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output ccsc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ccsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ccsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CMD_W = $bits(ccsc_pkg::cmd_type);
   localparam int RSP_W = $bits(ccsc_pkg::rsp_type);

   logic [8:0]        gen_poly_ff, gen_poly_in;
   logic [3:0]        gen_length_ff, gen_length_in;
   logic              dw_eight_ff, dw_eight_in;
   ccsc_pkg::cfg_type cfg;

   logic              cmd_push, cmd_full, cmd_empty, cmd_pop;
   ccsc_pkg::cmd_type cmd_in_data, cmd_out_data;
   logic [CMD_W-1:0]  cmd_out_flat;
   logic              back_push, back_full;
   ccsc_pkg::rsp_type back_data;
   logic [RSP_W-1:0]  rsp_flat;

   assign csr_ready = 1'b1;

   always_comb begin
      gen_poly_in   = gen_poly_ff;
      gen_length_in = gen_length_ff;
      dw_eight_in   = dw_eight_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ccsc_pkg::CSR_GEN_POLY:   gen_poly_in   = csr_wdata;
            ccsc_pkg::CSR_GEN_LENGTH: gen_length_in = csr_wdata[3:0];
            ccsc_pkg::CSR_DW_EIGHT:   dw_eight_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_poly_ff   <= ccsc_pkg::GEN_POLY_RST;
         gen_length_ff <= ccsc_pkg::GEN_LENGTH_RST;
         dw_eight_ff   <= ccsc_pkg::DW_EIGHT_RST;
      end else begin
         gen_poly_ff   <= gen_poly_in;
         gen_length_ff <= gen_length_in;
         dw_eight_ff   <= dw_eight_in;
      end
   end

   always_comb begin
      cfg.gen_poly   = gen_poly_ff;
      cfg.gen_length = ccsc_pkg::clamp_gen_length(gen_length_ff);
      cfg.dw_eight   = dw_eight_ff;
   end

   ccsc_front #(
      .BUFFER_BITS(BUFFER_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in_data),
      .cmd_full (cmd_full)
   );

   ccsc_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_flat),
      .empty     (cmd_empty)
   );

   assign cmd_out_data = ccsc_pkg::cmd_type'(cmd_out_flat);

   ccsc_back #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .rsp_push  (back_push),
      .rsp_data  (back_data),
      .rsp_full  (back_full)
   );

   ccsc_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_data),
      .full      (back_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_flat),
      .empty     (rsp_empty)
   );

   assign rsp_data = ccsc_pkg::rsp_type'(rsp_flat);

endmodule

/* rtl/ccsc_fifo.sv */
// small synchronous fifo used between front and back and on the result side
// depends on nothing; payload is a flat vector of WIDTH bits
`timescale 1ns / 1ps

module ccsc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/ccsc_front.sv */
// front part: takes stream bytes, gathers bits and cuts out codewords
// depends on ccsc_pkg; feeds check and clear commands into the command queue
`timescale 1ns / 1ps

module ccsc_front #(
   parameter int BUFFER_BITS = ccsc_pkg::BUFFER_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ccsc_pkg::cfg_type cfg,
   input  logic              req_push,
   input  ccsc_pkg::req_type req_data,
   output logic              req_full,
   output logic              cmd_push,
   output ccsc_pkg::cmd_type cmd_data,
   input  logic              cmd_full
);

   localparam int HW  = $clog2(BUFFER_BITS + 1);
   localparam int BW1 = BUFFER_BITS + 1;

   logic [BUFFER_BITS-1:0] buf_ff, buf_in;
   logic [HW-1:0]          held_ff, held_in;
   logic                   first_ff, first_in;
   logic [2:0]             pad_ff, pad_in;
   logic                   second_ff, second_in;

   logic                   accept;
   logic [7:0]             byte_mask;
   logic [3:0]             nbits;
   logic [BUFFER_BITS+7:0] app_wide;
   logic [BUFFER_BITS-1:0] app_buf;
   logic [HW:0]            app_sum;
   logic [HW-1:0]          app_held;

   logic [BUFFER_BITS-1:0] src_buf;
   logic [HW-1:0]          src_held;
   logic [HW-1:0]          cw_len;
   logic [HW-1:0]          src_rest;
   logic                   can_cut;
   logic [BUFFER_BITS-1:0] shifted;
   logic [16:0]            cw_mask;
   logic [15:0]            codeword;
   logic [15:0]            chk_mask;
   logic [BW1-1:0]         keep_mask;
   logic [BUFFER_BITS-1:0] cut_buf;
   logic [7:0]             cut_dw;
   logic [7:0]             cut_chk;

   assign req_full = second_ff || cmd_full;
   assign accept   = req_push && !req_full;

   // first data byte after a header drops its leading pad bits
   always_comb begin
      byte_mask = first_ff ? (8'hFF >> pad_ff) : 8'hFF;
      nbits     = first_ff ? (4'd8 - {1'b0, pad_ff}) : 4'd8;
      app_wide  = ({8'b0, buf_ff} << nbits) | (BUFFER_BITS + 8)'(req_data.data_byte & byte_mask);
      app_buf   = app_wide[BUFFER_BITS-1:0];
      app_sum   = (HW + 1)'(held_ff) + (HW + 1)'(nbits);
      app_held  = (app_sum > (HW + 1)'(BUFFER_BITS)) ? HW'(BUFFER_BITS) : app_sum[HW-1:0];
   end

   // cut one codeword off the top of the held bits
   always_comb begin
      src_buf   = second_ff ? buf_ff : app_buf;
      src_held  = second_ff ? held_ff : app_held;
      cw_len    = (cfg.dw_eight ? HW'(8) : HW'(4)) + HW'(cfg.gen_length) - HW'(1);
      can_cut   = (src_held >= cw_len);
      src_rest  = src_held - cw_len;
      shifted   = src_buf >> src_rest;
      cw_mask   = (17'd1 << cw_len) - 17'd1;
      codeword  = 16'(shifted) & cw_mask[15:0];
      chk_mask  = (16'd1 << (cfg.gen_length - 4'd1)) - 16'd1;
      cut_dw    = 8'(codeword >> (cfg.gen_length - 4'd1));
      cut_chk   = 8'(codeword & chk_mask);
      keep_mask = (BW1'(1) << src_rest) - BW1'(1);
      cut_buf   = src_buf & keep_mask[BUFFER_BITS-1:0];
   end

   always_comb begin
      buf_in              = buf_ff;
      held_in             = held_ff;
      first_in            = first_ff;
      pad_in              = pad_ff;
      second_in           = second_ff;
      cmd_push            = 1'b0;
      cmd_data.kind       = ccsc_pkg::CMD_CHECK;
      cmd_data.dataword   = cut_dw;
      cmd_data.check_bits = cut_chk;
      cmd_data.last       = 1'b1;
      if (second_ff) begin
         if (!cmd_full) begin
            second_in = 1'b0;
            if (can_cut) begin
               cmd_push = 1'b1;
               buf_in   = cut_buf;
               held_in  = src_rest;
            end
         end
      end else if (accept) begin
         if (req_data.mode == ccsc_pkg::MODE_HEADER) begin
            cmd_push      = 1'b1;
            cmd_data.kind = ccsc_pkg::CMD_CLEAR;
            buf_in        = '0;
            held_in       = '0;
            first_in      = 1'b1;
            pad_in        = req_data.data_byte[2:0];
         end else begin
            first_in = 1'b0;
            if (can_cut) begin
               cmd_push      = 1'b1;
               cmd_data.last = (src_rest < cw_len);
               second_in     = !(src_rest < cw_len);
               buf_in        = cut_buf;
               held_in       = src_rest;
            end else begin
               buf_in  = app_buf;
               held_in = app_held;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff    <= '0;
         held_ff   <= '0;
         first_ff  <= 1'b0;
         pad_ff    <= '0;
         second_ff <= 1'b0;
      end else begin
         buf_ff    <= buf_in;
         held_ff   <= held_in;
         first_ff  <= first_in;
         pad_ff    <= pad_in;
         second_ff <= second_in;
      end
   end

   a_held_in_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(BUFFER_BITS))
      else $error("front holds more bits than the buffer");

   a_second_drains: assert property (@(posedge clock) disable iff (reset)
      second_ff && !cmd_full |=> !second_ff)
      else $error("second codeword of a byte not taken");

   a_no_accept_during_second: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> !accept)
      else $error("request taken while second codeword pending");

endmodule

/* rtl/ccsc_back.sv */
// back part: crc remainder check, counters and dataword repacking
// depends on ccsc_pkg; reads the command queue and writes the result queue
`timescale 1ns / 1ps

module ccsc_back #(
   parameter int COUNT_WIDTH = ccsc_pkg::COUNT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ccsc_pkg::cfg_type cfg,
   input  logic              cmd_empty,
   input  ccsc_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_push,
   output ccsc_pkg::rsp_type rsp_data,
   input  logic              rsp_full
);

   logic [COUNT_WIDTH-1:0] cw_cnt_ff, cw_cnt_in;
   logic [COUNT_WIDTH-1:0] err_cnt_ff, err_cnt_in;
   logic [7:0]             pack_ff, pack_in;
   logic [3:0]             pack_bits_ff, pack_bits_in;

   logic        go;
   logic [3:0]  dlen;
   logic [15:0] gen16;
   logic [15:0] work;
   logic [15:0] rem_mask;
   logic        err;
   logic [15:0] acc;
   logic [3:0]  nb;
   logic        byte_done;
   logic [7:0]  byte_out;
   logic [3:0]  nb_left;

   assign go      = !cmd_empty && !rsp_full;
   assign cmd_pop = go;
   assign dlen    = cfg.dw_eight ? 4'd8 : 4'd4;

   // modulo-2 long division, one dataword bit per step
   always_comb begin
      gen16    = 16'(cfg.gen_poly & ((9'd1 << cfg.gen_length) - 9'd1));
      work     = 16'(cmd_data.dataword) << (cfg.gen_length - 4'd1);
      for (int i = 7; i >= 0; i--) begin
         if (i < int'(dlen) && work[i + int'(cfg.gen_length) - 1]) begin
            work = work ^ (gen16 << i);
         end
      end
      rem_mask = (16'd1 << (cfg.gen_length - 4'd1)) - 16'd1;
      err      = ((work & rem_mask) != 16'(cmd_data.check_bits));
   end

   always_comb begin
      acc       = (16'(pack_ff) << dlen) | 16'(cmd_data.dataword);
      nb        = pack_bits_ff + dlen;
      byte_done = (nb >= 4'd8);
      byte_out  = byte_done ? 8'(acc >> (nb - 4'd8)) : 8'd0;
      nb_left   = byte_done ? nb - 4'd8 : nb;
   end

   always_comb begin
      cw_cnt_in    = cw_cnt_ff;
      err_cnt_in   = err_cnt_ff;
      pack_in      = pack_ff;
      pack_bits_in = pack_bits_ff;
      rsp_push     = 1'b0;
      if (go) begin
         if (cmd_data.kind == ccsc_pkg::CMD_CLEAR) begin
            cw_cnt_in    = '0;
            err_cnt_in   = '0;
            pack_in      = '0;
            pack_bits_in = '0;
         end else begin
            rsp_push     = 1'b1;
            cw_cnt_in    = cw_cnt_ff + COUNT_WIDTH'(1);
            err_cnt_in   = err ? err_cnt_ff + COUNT_WIDTH'(1) : err_cnt_ff;
            pack_in      = 8'(acc & ((16'd1 << nb_left) - 16'd1));
            pack_bits_in = nb_left;
         end
      end
   end

   always_comb begin
      rsp_data.codeword_error = err;
      rsp_data.out_byte_valid = byte_done;
      rsp_data.out_byte       = byte_out;
      rsp_data.codeword_total = 32'(cw_cnt_in);
      rsp_data.error_total    = 32'(err_cnt_in);
      rsp_data.last           = cmd_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_cnt_ff    <= '0;
         err_cnt_ff   <= '0;
         pack_ff      <= '0;
         pack_bits_ff <= '0;
      end else begin
         cw_cnt_ff    <= cw_cnt_in;
         err_cnt_ff   <= err_cnt_in;
         pack_ff      <= pack_in;
         pack_bits_ff <= pack_bits_in;
      end
   end

   a_pack_partial: assert property (@(posedge clock) disable iff (reset)
      pack_bits_ff < 4'd8)
      else $error("packer holds a full byte");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full && !cmd_empty)
      else $error("result written without room or command");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> cw_cnt_ff == $past(cw_cnt_ff) + COUNT_WIDTH'(1))
      else $error("codeword count did not advance");

endmodule
